### rtl/gmh_pkg.sv
// Shared constants, types and table functions for the GPS movement gate.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none
package gmh_pkg;

  localparam int CORDIC_ITER_DEF = 24;
  localparam int ANGLE_FRAC_DEF  = 30;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int MIN_W  = 16;
  localparam int DIST_W = 25;
  localparam int U_W    = 33;

  localparam int LAT_ANGLE  = 4;
  localparam int LAT_HAV    = 5;
  localparam int SQRT_STEPS = 32;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029481305;
  localparam logic [63:0] HALF_DIV = 64'd3600000000;
  localparam logic [63:0] HALF_SCALE_Q91 =
    ((PI_Q60 / HALF_DIV) << 31) + (((PI_Q60 % HALF_DIV) << 31) / HALF_DIV);
  localparam logic [31:0] HS_HI = HALF_SCALE_Q91[62:31];
  localparam logic [30:0] HS_LO = HALF_SCALE_Q91[30:0];

  localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [23:0] TWO_R    = 24'd12742000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [MIN_W-1:0]  MIN_MOVE_RST = 16'd5;

  typedef enum logic [0:0] {
    CFG_ENABLE   = 1'b0,
    CFG_MIN_MOVE = 1'b1
  } cfg_idx_t;

  // one word travelling beside the arithmetic pipeline
  typedef struct packed {
    logic                    vld;
    logic                    fix;
    logic signed [LAT_W-1:0] cur_lat;
    logic signed [LON_W-1:0] cur_lon;
    logic signed [LAT_W-1:0] ref_lat;
    logic signed [LON_W-1:0] ref_lon;
  } item_t;

  // atan(2^-i) in Q62 from the truncated power series
  function automatic logic [63:0] atan_q62(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q60;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'd1 << e) / 64'(2 * k + 1);
          acc = (k % 2 == 1) ? acc - term : acc + term;
        end
      end
    end
    return acc;
  endfunction

  // table entry rounded to the angle format
  function automatic logic [63:0] atan_qf(input int i, input int f);
    logic [63:0] t;
    t = atan_q62(i);
    return (t + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

endpackage
`default_nettype wire

### rtl/gmh_delay.sv
// Shift line that carries the item word and its valid bit beside the math.
// Depends on gmh_pkg for item_t.
`default_nettype none
module gmh_delay #(
  parameter int DEPTH = 90
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gmh_pkg::item_t d_in,
  output gmh_pkg::item_t d_out
);

  gmh_pkg::item_t pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        pipe_r[k].vld <= 1'b0;
      end
    end else begin
      pipe_r[0] <= d_in;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_r[k] <= pipe_r[k-1];
      end
    end
  end

  assign d_out = pipe_r[DEPTH-1];

endmodule
`default_nettype wire

### rtl/gmh_angle.sv
// Degree units to a half angle in radians, wrapped and folded for CORDIC.
// Depends on gmh_pkg for the pi and scale constants. Four stages.
`default_nettype none
module gmh_angle #(
  parameter int F = gmh_pkg::ANGLE_FRAC_DEF,
  parameter int W = gmh_pkg::ANGLE_FRAC_DEF + 4
) (
  input  logic                          clk,
  input  logic signed [gmh_pkg::U_W-1:0] u_in,
  output logic signed [W-1:0]           ang,
  output logic                          neg
);

  localparam int SH = 91 - F;
  localparam logic [96:0] RND = 97'(1) << (SH - 1);
  localparam logic signed [W-1:0] PI_W =
    W'((gmh_pkg::PI_Q60 + (64'd1 << (59 - F))) >> (60 - F));
  localparam logic signed [W-1:0] TWO_PI  = PI_W + PI_W;
  localparam logic signed [W-1:0] HALF_PI = PI_W >>> 1;

  logic signed [gmh_pkg::U_W-1:0] u_r;
  logic [64:0] pp_hi_r;
  logic [63:0] pp_lo_r;
  logic        sgn_r;
  logic signed [W-1:0] a_r;
  logic signed [W-1:0] ang_r;
  logic        neg_r;

  logic [gmh_pkg::U_W-1:0] mag;
  logic [96:0]        sum;
  logic signed [W-1:0] r, a_nxt, w, ang_nxt;
  logic               neg_nxt;

  always_comb begin
    mag   = u_r[gmh_pkg::U_W-1] ? gmh_pkg::U_W'(-u_r) : gmh_pkg::U_W'(u_r);
    sum   = (97'(pp_hi_r) << 31) + 97'(pp_lo_r) + RND;
    r     = W'(sum >> SH);
    a_nxt = sgn_r ? -r : r;
    // wrap to [-pi, pi]
    if (a_r > PI_W) begin
      w = a_r - TWO_PI;
    end else if (a_r < -PI_W) begin
      w = a_r + TWO_PI;
    end else begin
      w = a_r;
    end
    // fold to [-pi/2, pi/2], negate results later
    if (w > HALF_PI) begin
      ang_nxt = w - PI_W;
      neg_nxt = 1'b1;
    end else if (w < -HALF_PI) begin
      ang_nxt = w + PI_W;
      neg_nxt = 1'b1;
    end else begin
      ang_nxt = w;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    u_r     <= u_in;
    pp_hi_r <= 65'(mag) * 65'(gmh_pkg::HS_HI);
    pp_lo_r <= 64'(mag) * 64'(gmh_pkg::HS_LO);
    sgn_r   <= u_r[gmh_pkg::U_W-1];
    a_r     <= a_nxt;
    ang_r   <= ang_nxt;
    neg_r   <= neg_nxt;
  end

  assign ang = ang_r;
  assign neg = neg_r;

endmodule
`default_nettype wire

### rtl/gmh_rot.sv
// Rotation CORDIC giving sine and cosine, one iteration per stage.
// Depends on gmh_pkg for the gain and arctangent table.
`default_nettype none
module gmh_rot #(
  parameter int N = gmh_pkg::CORDIC_ITER_DEF,
  parameter int F = gmh_pkg::ANGLE_FRAC_DEF,
  parameter int W = gmh_pkg::ANGLE_FRAC_DEF + 4
) (
  input  logic                clk,
  input  logic signed [W-1:0] ang_in,
  input  logic                neg_in,
  output logic signed [W-1:0] sn,
  output logic signed [W-1:0] cs
);

  localparam logic signed [W-1:0] K0 =
    W'((gmh_pkg::GAIN_Q62 + (64'd1 << (61 - F))) >> (62 - F));

  function automatic logic signed [W-1:0] atan_w(input int i);
    return W'(gmh_pkg::atan_qf(i, F));
  endfunction

  logic signed [W-1:0] x_r [N];
  logic signed [W-1:0] y_r [N];
  logic signed [W-1:0] a_r [N];
  logic                n_r [N];
  logic signed [W-1:0] xp [N];
  logic signed [W-1:0] yp [N];
  logic signed [W-1:0] ap [N];
  logic                np [N];

  always_comb begin
    xp[0] = K0;
    yp[0] = '0;
    ap[0] = ang_in;
    np[0] = neg_in;
    for (int i = 1; i < N; i++) begin
      xp[i] = x_r[i-1];
      yp[i] = y_r[i-1];
      ap[i] = a_r[i-1];
      np[i] = n_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      n_r[i] <= np[i];
      if (!ap[i][W-1]) begin
        x_r[i] <= xp[i] - (yp[i] >>> i);
        y_r[i] <= yp[i] + (xp[i] >>> i);
        a_r[i] <= ap[i] - atan_w(i);
      end else begin
        x_r[i] <= xp[i] + (yp[i] >>> i);
        y_r[i] <= yp[i] - (xp[i] >>> i);
        a_r[i] <= ap[i] + atan_w(i);
      end
    end
  end

  assign sn = n_r[N-1] ? -y_r[N-1] : y_r[N-1];
  assign cs = n_r[N-1] ? -x_r[N-1] : x_r[N-1];

endmodule
`default_nettype wire

### rtl/gmh_hav.sv
// Haversine term h = sin^2 + cos*cos*sin^2 in Q62, clamped to [0, 1].
// Depends on gmh_pkg for Q62_ONE. Five stages, long product cut in four.
`default_nettype none
module gmh_hav #(
  parameter int F = gmh_pkg::ANGLE_FRAC_DEF,
  parameter int W = gmh_pkg::ANGLE_FRAC_DEF + 4
) (
  input  logic                clk,
  input  logic signed [W-1:0] s1,
  input  logic signed [W-1:0] s2,
  input  logic signed [W-1:0] c1,
  input  logic signed [W-1:0] c2,
  output logic [62:0]         h,
  output logic [62:0]         omh
);

  localparam int PW  = 2 * F + 2;
  localparam int SHR = (2 * F >= 62) ? 2 * F - 62 : 0;
  localparam int SHL = (2 * F < 62) ? 62 - 2 * F : 0;
  localparam logic [127:0] RND = (128'd1 << SHR) >> 1;
  localparam logic [F:0]   ONE_F = (F+1)'(1) << F;

  function automatic logic [F:0] mag_one(input logic signed [W-1:0] v);
    logic [W-1:0] m;
    m = v[W-1] ? W'(-v) : W'(v);
    return (m > W'(ONE_F)) ? ONE_F : m[F:0];
  endfunction

  function automatic logic [62:0] to_q62(input logic [PW-1:0] p);
    logic [127:0] t;
    t = ((128'(p) << SHL) + RND) >> SHR;
    return t[62:0];
  endfunction

  logic [PW-1:0] hp_r, sp_r, cp_r;
  logic          flip1_r, flip2_r, flip3_r, flip4_r;
  logic [62:0]   h2_r, s2_r, cc2_r, h3_r, h4_r;
  logic [63:0]   pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [62:0]   t4_r;
  logic [62:0]   h_r, omh_r;

  logic [127:0] psum;
  logic [63:0]  hs, hc;

  always_comb begin
    psum = (128'(pp_hh_r) << 64) + (128'(pp_hl_r) << 32) + (128'(pp_lh_r) << 32)
         + 128'(pp_ll_r) + (128'd1 << 61);
    if (flip4_r) begin
      hs = (h4_r > t4_r) ? 64'(h4_r) - 64'(t4_r) : 64'd0;
    end else begin
      hs = 64'(h4_r) + 64'(t4_r);
    end
    hc = (hs > gmh_pkg::Q62_ONE) ? gmh_pkg::Q62_ONE : hs;
  end

  always_ff @(posedge clk) begin
    // square and cross products of clamped magnitudes
    hp_r    <= PW'(mag_one(s1)) * PW'(mag_one(s1));
    sp_r    <= PW'(mag_one(s2)) * PW'(mag_one(s2));
    cp_r    <= PW'(mag_one(c1)) * PW'(mag_one(c2));
    flip1_r <= c1[W-1] != c2[W-1];
    // round to Q62
    h2_r    <= to_q62(hp_r);
    s2_r    <= to_q62(sp_r);
    cc2_r   <= to_q62(cp_r);
    flip2_r <= flip1_r;
    // partial products of cc * sin^2
    pp_hh_r <= 64'(cc2_r[62:32]) * 64'(s2_r[62:32]);
    pp_hl_r <= 64'(cc2_r[62:32]) * 64'(s2_r[31:0]);
    pp_lh_r <= 64'(cc2_r[31:0]) * 64'(s2_r[62:32]);
    pp_ll_r <= 64'(cc2_r[31:0]) * 64'(s2_r[31:0]);
    h3_r    <= h2_r;
    flip3_r <= flip2_r;
    t4_r    <= psum[124:62];
    h4_r    <= h3_r;
    flip4_r <= flip3_r;
    h_r     <= hc[62:0];
    omh_r   <= 63'(gmh_pkg::Q62_ONE - hc);
  end

  assign h   = h_r;
  assign omh = omh_r;

endmodule
`default_nettype wire

### rtl/gmh_isqrt.sv
// Integer square root of a Q62 value, one result bit per stage.
// Depends on gmh_pkg for the step count.
`default_nettype none
module gmh_isqrt (
  input  logic        clk,
  input  logic [62:0] n_in,
  output logic [31:0] root
);

  localparam int S = gmh_pkg::SQRT_STEPS;

  logic [62:0] n_r [S];
  logic [62:0] r_r [S];
  logic [62:0] np  [S];
  logic [62:0] rp  [S];
  logic [63:0] trial [S];

  always_comb begin
    np[0] = n_in;
    rp[0] = '0;
    for (int j = 1; j < S; j++) begin
      np[j] = n_r[j-1];
      rp[j] = r_r[j-1];
    end
    for (int j = 0; j < S; j++) begin
      trial[j] = 64'(rp[j]) + (64'd1 << (62 - 2 * j));
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < S; j++) begin
      if (64'(np[j]) >= trial[j]) begin
        n_r[j] <= 63'(64'(np[j]) - trial[j]);
        r_r[j] <= 63'((64'(rp[j]) >> 1) + (64'd1 << (62 - 2 * j)));
      end else begin
        n_r[j] <= np[j];
        r_r[j] <= rp[j] >> 1;
      end
    end
  end

  assign root = r_r[S-1][31:0];

endmodule
`default_nettype wire

### rtl/gmh_vec.sv
// Vectoring CORDIC for atan2(sqrt h, sqrt(1-h)), then scaling by 2R.
// Depends on gmh_pkg for the table and radius. N + 1 stages.
`default_nettype none
module gmh_vec #(
  parameter int N = gmh_pkg::CORDIC_ITER_DEF,
  parameter int F = gmh_pkg::ANGLE_FRAC_DEF,
  parameter int W = gmh_pkg::ANGLE_FRAC_DEF + 4
) (
  input  logic          clk,
  input  logic [31:0]   ry,
  input  logic [31:0]   rx,
  output logic [F+24:0] prod
);

  function automatic logic signed [W-1:0] atan_w(input int i);
    return W'(gmh_pkg::atan_qf(i, F));
  endfunction

  logic signed [63:0]  x_r [N];
  logic signed [63:0]  y_r [N];
  logic signed [W-1:0] z_r [N];
  logic signed [63:0]  xp [N];
  logic signed [63:0]  yp [N];
  logic signed [W-1:0] zp [N];
  logic [F:0]          zc;
  logic [F+24:0]       prod_r;

  always_comb begin
    xp[0] = 64'(rx) << 29;
    yp[0] = 64'(ry) << 29;
    zp[0] = '0;
    for (int i = 1; i < N; i++) begin
      xp[i] = x_r[i-1];
      yp[i] = y_r[i-1];
      zp[i] = z_r[i-1];
    end
    zc = z_r[N-1][W-1] ? '0 : z_r[N-1][F:0];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (!yp[i][63]) begin
        x_r[i] <= xp[i] + (yp[i] >>> i);
        y_r[i] <= yp[i] - (xp[i] >>> i);
        z_r[i] <= zp[i] + atan_w(i);
      end else begin
        x_r[i] <= xp[i] - (yp[i] >>> i);
        y_r[i] <= yp[i] + (xp[i] >>> i);
        z_r[i] <= zp[i] - atan_w(i);
      end
    end
    prod_r <= (F+25)'(zc) * (F+25)'(gmh_pkg::TWO_R);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

### rtl/gps_move_gate_haversine.sv
// GPS movement gate: haversine distance between a fix and a reference.
// Depends on gmh_pkg and the gmh_angle, gmh_rot, gmh_hav, gmh_isqrt,
// gmh_vec and gmh_delay modules.
//
// Usage:
//   Input channel: raise start with the five in_ fields; the word is taken
//   at every rising edge with start high and busy low. busy stays low, so a
//   new word can enter on every cycle.
//   Result channel: one result word per input word, on the out_ ports for
//   exactly one cycle while out_valid is high, in input order. The receiver
//   cannot stall; nothing in this block holds or drops a word.
//   Pipeline: the two CORDIC chains and the 32 step square root take one
//   stage per iteration or step.
//   Throughput: one word per cycle.
//   Configuration: cfg_we with cfg_idx and cfg_wdata writes enable (bit 0)
//   or min_move_metres; write only while no word is in flight.
//   Reset: synchronous, active low; clears all valid bits in flight and
//   sets enable = 0, min_move_metres = 5. Datapath registers are not reset.
`default_nettype none
module gps_move_gate_haversine #(
  parameter int CORDIC_ITERATIONS   = gmh_pkg::CORDIC_ITER_DEF,
  parameter int ANGLE_FRACTION_BITS = gmh_pkg::ANGLE_FRAC_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // input channel
  input  logic start,
  output logic busy,
  input  logic signed [gmh_pkg::LAT_W-1:0] in_cur_lat,
  input  logic signed [gmh_pkg::LON_W-1:0] in_cur_lon,
  input  logic                             in_has_fix,
  input  logic signed [gmh_pkg::LAT_W-1:0] in_ref_lat,
  input  logic signed [gmh_pkg::LON_W-1:0] in_ref_lon,
  // result channel
  output logic                              out_valid,
  output logic                              out_moved,
  output logic signed [gmh_pkg::LAT_W-1:0]  out_new_lat,
  output logic signed [gmh_pkg::LON_W-1:0]  out_new_lon,
  output logic [gmh_pkg::DIST_W-1:0]        out_distance_m,
  // configuration
  input  logic                     cfg_we,
  input  logic                     cfg_idx,
  input  logic [gmh_pkg::MIN_W-1:0] cfg_wdata
);

  localparam int N   = CORDIC_ITERATIONS;
  localparam int F   = ANGLE_FRACTION_BITS;
  localparam int W   = F + 4;
  localparam int LAT = gmh_pkg::LAT_ANGLE + N + gmh_pkg::LAT_HAV
                     + gmh_pkg::SQRT_STEPS + N + 1 + 1;
  localparam int PRW = F + 25;
  localparam logic [PRW:0] RND_D = (PRW+1)'(1) << (F - 1);

  localparam int UW = gmh_pkg::U_W;

  // configuration registers
  logic                      enable_r;
  logic [gmh_pkg::MIN_W-1:0] min_move_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      min_move_r <= gmh_pkg::MIN_MOVE_RST;
    end else if (cfg_we) begin
      case (gmh_pkg::cfg_idx_t'(cfg_idx))
        gmh_pkg::CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        gmh_pkg::CFG_MIN_MOVE: min_move_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the block never holds the input off
  assign busy = 1'b0;

  // angle arguments in 1e-7 degree units: differences and doubled latitudes
  logic signed [UW-1:0] u_dlat, u_dlon, u_lat_r, u_lat_c;

  assign u_dlat  = {{2{in_cur_lat[gmh_pkg::LAT_W-1]}}, in_cur_lat}
                 - {{2{in_ref_lat[gmh_pkg::LAT_W-1]}}, in_ref_lat};
  assign u_dlon  = {in_cur_lon[gmh_pkg::LON_W-1], in_cur_lon}
                 - {in_ref_lon[gmh_pkg::LON_W-1], in_ref_lon};
  assign u_lat_r = {in_ref_lat[gmh_pkg::LAT_W-1], in_ref_lat, 1'b0};
  assign u_lat_c = {in_cur_lat[gmh_pkg::LAT_W-1], in_cur_lat, 1'b0};

  // four angle lanes: half dlat, half dlon, reference and current latitude
  logic signed [W-1:0] ang [4];
  logic                fneg [4];
  logic signed [W-1:0] sn [4];
  logic signed [W-1:0] cs [4];
  logic signed [UW-1:0] u_lane [4];

  assign u_lane[0] = u_dlat;
  assign u_lane[1] = u_dlon;
  assign u_lane[2] = u_lat_r;
  assign u_lane[3] = u_lat_c;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    gmh_angle #(.F(F), .W(W)) u_angle (
      .clk   (clk),
      .u_in  (u_lane[g]),
      .ang   (ang[g]),
      .neg   (fneg[g])
    );
    gmh_rot #(.N(N), .F(F), .W(W)) u_rot (
      .clk    (clk),
      .ang_in (ang[g]),
      .neg_in (fneg[g]),
      .sn     (sn[g]),
      .cs     (cs[g])
    );
  end

  // haversine term and its complement
  logic [62:0] h, omh;

  gmh_hav #(.F(F), .W(W)) u_hav (
    .clk (clk),
    .s1  (sn[0]),
    .s2  (sn[1]),
    .c1  (cs[2]),
    .c2  (cs[3]),
    .h   (h),
    .omh (omh)
  );

  logic [31:0] root_h, root_omh;

  gmh_isqrt u_sqrt_h (
    .clk  (clk),
    .n_in (h),
    .root (root_h)
  );

  gmh_isqrt u_sqrt_omh (
    .clk  (clk),
    .n_in (omh),
    .root (root_omh)
  );

  // half the central angle times 2R, before rounding to whole metres
  logic [PRW-1:0] prod;

  gmh_vec #(.N(N), .F(F), .W(W)) u_vec (
    .clk  (clk),
    .ry   (root_h),
    .rx   (root_omh),
    .prod (prod)
  );

  // carry positions, fix flag and valid bit beside the math
  gmh_pkg::item_t item_in, item_out;

  always_comb begin
    item_in.vld     = start & ~busy;
    item_in.fix     = in_has_fix;
    item_in.cur_lat = in_cur_lat;
    item_in.cur_lon = in_cur_lon;
    item_in.ref_lat = in_ref_lat;
    item_in.ref_lon = in_ref_lon;
  end

  gmh_delay #(.DEPTH(LAT - 1)) u_delay (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (item_in),
    .d_out (item_out)
  );

  // output stage: round, saturate, gate and pick the position to pass
  logic [PRW:0]                dsum;
  logic [PRW-F:0]              dq;
  logic [gmh_pkg::DIST_W-1:0]  dsat, dist_nxt;
  logic                        gate, moved_nxt;

  logic                              out_valid_r;
  logic                              out_moved_r;
  logic signed [gmh_pkg::LAT_W-1:0]  out_lat_r;
  logic signed [gmh_pkg::LON_W-1:0]  out_lon_r;
  logic [gmh_pkg::DIST_W-1:0]        out_dist_r;

  always_comb begin
    dsum      = (PRW+1)'(prod) + RND_D;
    dq        = (PRW-F+1)'(dsum >> F);
    dsat      = (dq > (PRW-F+1)'(gmh_pkg::DIST_MAX)) ? gmh_pkg::DIST_MAX
                                                     : dq[gmh_pkg::DIST_W-1:0];
    gate      = enable_r & item_out.fix;
    dist_nxt  = gate ? dsat : '0;
    moved_nxt = gate && (dsat >= gmh_pkg::DIST_W'(min_move_r));
  end

  always_ff @(posedge clk) begin
    out_moved_r <= moved_nxt;
    out_lat_r   <= moved_nxt ? item_out.cur_lat : item_out.ref_lat;
    out_lon_r   <= moved_nxt ? item_out.cur_lon : item_out.ref_lon;
    out_dist_r  <= dist_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_out.vld;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_moved      = out_moved_r;
  assign out_new_lat    = out_lat_r;
  assign out_new_lon    = out_lon_r;
  assign out_distance_m = out_dist_r;

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("result word missing at fixed latency");

  // a move is only reported at or above the threshold
  a_thresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |-> out_distance_m >= gmh_pkg::DIST_W'(min_move_r))
    else $error("move reported below threshold");

  // disabled gate reports no move and zero distance
  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !enable_r |-> !out_moved && out_distance_m == '0)
    else $error("disabled gate reported a distance or move");

endmodule
`default_nettype wire
